FILE: rtl/uvc_pkg.sv
`timescale 1ns / 1ps

package uvc_pkg;

    localparam int VALUE_W = 32;
    localparam int COUNT_W = 11;
    localparam int SLOT_CNT_W = 2;

    // Saturating per-slot occurrence count
    localparam logic [SLOT_CNT_W-1:0] CNT_EMPTY = 2'd0;
    localparam logic [SLOT_CNT_W-1:0] CNT_ONCE  = 2'd1;
    localparam logic [SLOT_CNT_W-1:0] CNT_MANY  = 2'd2;

    // Reported total saturates here
    localparam logic [COUNT_W-1:0] UNIQUE_MAX = 11'd2047;

    typedef struct packed {
        logic [SLOT_CNT_W-1:0] count;
        logic [VALUE_W-1:0]    key;
    } slot_t;

    typedef struct packed {
        logic               overflow;
        logic [COUNT_W-1:0] singles;
    } result_t;

    typedef struct packed {
        logic rd_en;
        logic wr_en;
    } ram_cmd_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_HASH,
        ST_READ,
        ST_CHECK,
        ST_REPORT
    } state_t;

endpackage

FILE: rtl/uvc_mod_unit.sv
`timescale 1ns / 1ps

// Home slot = value mod TABLE_DEPTH.
// Power-of-two depth: a mask. Otherwise a restoring remainder unit, four
// compare/subtract steps per cycle over the 32-bit value.
module uvc_mod_unit #(
    parameter int TABLE_DEPTH = 1024
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           start,
    input  logic [uvc_pkg::VALUE_W-1:0]    value_in,
    output logic                           done,
    output logic [$clog2(TABLE_DEPTH)-1:0] rem
);

    localparam int RW = $clog2(TABLE_DEPTH);
    localparam bit IS_POW2 = (TABLE_DEPTH & (TABLE_DEPTH - 1)) == 0;

    logic          done_reg;
    logic [RW-1:0] rem_reg;

    assign done = done_reg;
    assign rem  = rem_reg;

    generate
        if (IS_POW2) begin : g_mask
            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    done_reg <= 1'b0;
                end else begin
                    done_reg <= start;
                end
                if (start) begin
                    rem_reg <= value_in[RW-1:0];
                end
            end
        end else begin : g_serial
            localparam int BITS_PER_STEP = 4;
            localparam int STEPS = uvc_pkg::VALUE_W / BITS_PER_STEP;
            localparam int SW = $clog2(STEPS);
            localparam logic [RW:0] DEPTH_W = (RW + 1)'(TABLE_DEPTH);

            logic                        busy_reg;
            logic [SW-1:0]               step_reg;
            logic [uvc_pkg::VALUE_W-1:0] div_reg;
            logic [RW-1:0]               rem_step;

            always_comb begin
                logic [RW:0] trial;
                rem_step = rem_reg;
                for (int i = 0; i < BITS_PER_STEP; i++) begin
                    trial = {rem_step, div_reg[uvc_pkg::VALUE_W-1-i]};
                    if (trial >= DEPTH_W) begin
                        trial = trial - DEPTH_W;
                    end
                    rem_step = trial[RW-1:0];
                end
            end

            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b0;
                    step_reg <= '0;
                end else begin
                    done_reg <= 1'b0;
                    if (start) begin
                        busy_reg <= 1'b1;
                        step_reg <= '0;
                    end else if (busy_reg) begin
                        step_reg <= step_reg + 1'b1;
                        if (step_reg == SW'(STEPS - 1)) begin
                            busy_reg <= 1'b0;
                            done_reg <= 1'b1;
                        end
                    end
                end
                if (start) begin
                    div_reg <= value_in;
                    rem_reg <= '0;
                end else if (busy_reg) begin
                    div_reg <= div_reg << BITS_PER_STEP;
                    rem_reg <= rem_step;
                end
            end
        end
    endgenerate

endmodule

FILE: rtl/uvc_slot_ram.sv
`timescale 1ns / 1ps

// Single-port slot store, registered read.
module uvc_slot_ram #(
    parameter int TABLE_DEPTH = 1024
) (
    input  logic                           aclk,
    input  uvc_pkg::ram_cmd_t              cmd,
    input  logic [$clog2(TABLE_DEPTH)-1:0] addr,
    input  uvc_pkg::slot_t                 wdata,
    output uvc_pkg::slot_t                 rdata
);

    uvc_pkg::slot_t mem [TABLE_DEPTH];
    uvc_pkg::slot_t rdata_reg;

    assign rdata = rdata_reg;

    always_ff @(posedge aclk) begin
        if (cmd.wr_en) begin
            mem[addr] <= wdata;
        end
        if (cmd.rd_en) begin
            rdata_reg <= mem[addr];
        end
    end

endmodule

FILE: rtl/uvc_probe_ctrl.sv
`timescale 1ns / 1ps

// Sequencer: hash, linear probe, per-set totals, report and clear sweep.
module uvc_probe_ctrl #(
    parameter int TABLE_DEPTH = 1024
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           in_valid,
    input  logic [uvc_pkg::VALUE_W-1:0]    in_value,
    input  logic                           in_last,
    output logic                           in_ready,
    output logic                           mod_start,
    input  logic                           mod_done,
    input  logic [$clog2(TABLE_DEPTH)-1:0] mod_rem,
    output uvc_pkg::ram_cmd_t              ram_cmd,
    output logic [$clog2(TABLE_DEPTH)-1:0] ram_addr,
    output uvc_pkg::slot_t                 ram_wdata,
    input  uvc_pkg::slot_t                 ram_rdata,
    input  logic                           out_free,
    output logic                           res_valid,
    output uvc_pkg::result_t               res_data
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int TW = $clog2(TABLE_DEPTH + 1);
    localparam int CW = (TW > uvc_pkg::COUNT_W) ? TW : uvc_pkg::COUNT_W;
    localparam logic [AW-1:0] LAST_SLOT = AW'(TABLE_DEPTH - 1);

    uvc_pkg::state_t state_reg, state_next;

    logic [uvc_pkg::VALUE_W-1:0] value_reg, value_next;
    logic                        last_reg, last_next;
    logic [AW-1:0]               pos_reg, pos_next;
    logic [AW-1:0]               tries_reg, tries_next;
    logic [AW-1:0]               clr_reg, clr_next;
    logic [TW-1:0]               total_reg, total_next;
    logic                        full_reg, full_next;

    logic          slot_empty;
    logic          slot_hit;
    logic          last_try;
    logic          probe_end;
    logic [AW-1:0] pos_inc;
    logic [CW-1:0] total_ext;

    assign slot_empty = ram_rdata.count == uvc_pkg::CNT_EMPTY;
    assign slot_hit   = !slot_empty && (ram_rdata.key == value_reg);
    assign last_try   = tries_reg == LAST_SLOT;
    assign probe_end  = slot_empty || slot_hit || last_try;
    assign pos_inc    = (pos_reg == LAST_SLOT) ? '0 : pos_reg + 1'b1;

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            uvc_pkg::ST_CLEAR: begin
                if (clr_reg == LAST_SLOT) begin
                    state_next = uvc_pkg::ST_IDLE;
                end
            end
            uvc_pkg::ST_IDLE: begin
                if (in_valid) begin
                    state_next = uvc_pkg::ST_HASH;
                end
            end
            uvc_pkg::ST_HASH: begin
                if (mod_done) begin
                    state_next = uvc_pkg::ST_READ;
                end
            end
            uvc_pkg::ST_READ: begin
                state_next = uvc_pkg::ST_CHECK;
            end
            uvc_pkg::ST_CHECK: begin
                if (probe_end) begin
                    state_next = last_reg ? uvc_pkg::ST_REPORT : uvc_pkg::ST_IDLE;
                end else begin
                    state_next = uvc_pkg::ST_READ;
                end
            end
            uvc_pkg::ST_REPORT: begin
                if (out_free) begin
                    state_next = uvc_pkg::ST_CLEAR;
                end
            end
            default: begin
                state_next = uvc_pkg::ST_CLEAR;
            end
        endcase
    end

    // Datapath next values
    always_comb begin
        value_next = value_reg;
        last_next  = last_reg;
        pos_next   = pos_reg;
        tries_next = tries_reg;
        clr_next   = clr_reg;
        total_next = total_reg;
        full_next  = full_reg;
        case (state_reg)
            uvc_pkg::ST_CLEAR: begin
                clr_next = (clr_reg == LAST_SLOT) ? '0 : clr_reg + 1'b1;
            end
            uvc_pkg::ST_IDLE: begin
                if (in_valid) begin
                    value_next = in_value;
                    last_next  = in_last;
                    tries_next = '0;
                end
            end
            uvc_pkg::ST_HASH: begin
                if (mod_done) begin
                    pos_next = mod_rem;
                end
            end
            uvc_pkg::ST_CHECK: begin
                if (slot_empty) begin
                    total_next = total_reg + 1'b1;
                end else if (slot_hit) begin
                    if (ram_rdata.count == uvc_pkg::CNT_ONCE) begin
                        total_next = total_reg - 1'b1;
                    end
                end else if (last_try) begin
                    full_next = 1'b1;
                end else begin
                    pos_next   = pos_inc;
                    tries_next = tries_reg + 1'b1;
                end
            end
            uvc_pkg::ST_REPORT: begin
                if (out_free) begin
                    total_next = '0;
                    full_next  = 1'b0;
                    clr_next   = '0;
                end
            end
            default: begin
                clr_next = clr_reg;
            end
        endcase
    end

    // Outputs
    always_comb begin
        in_ready  = 1'b0;
        mod_start = 1'b0;
        res_valid = 1'b0;
        ram_cmd   = '0;
        ram_addr  = pos_reg;
        ram_wdata = '0;
        case (state_reg)
            uvc_pkg::ST_CLEAR: begin
                ram_cmd.wr_en = 1'b1;
                ram_addr      = clr_reg;
            end
            uvc_pkg::ST_IDLE: begin
                in_ready  = 1'b1;
                mod_start = in_valid;
            end
            uvc_pkg::ST_READ: begin
                ram_cmd.rd_en = 1'b1;
            end
            uvc_pkg::ST_CHECK: begin
                ram_wdata.key = value_reg;
                if (slot_empty) begin
                    ram_cmd.wr_en   = 1'b1;
                    ram_wdata.count = uvc_pkg::CNT_ONCE;
                end else if (slot_hit && ram_rdata.count == uvc_pkg::CNT_ONCE) begin
                    ram_cmd.wr_en   = 1'b1;
                    ram_wdata.count = uvc_pkg::CNT_MANY;
                end
            end
            uvc_pkg::ST_REPORT: begin
                res_valid = out_free;
            end
            default: begin
                in_ready = 1'b0;
            end
        endcase
    end

    assign total_ext = CW'(total_reg);
    assign res_data.singles = (total_ext > CW'(uvc_pkg::UNIQUE_MAX)) ?
                              uvc_pkg::UNIQUE_MAX : total_ext[uvc_pkg::COUNT_W-1:0];
    assign res_data.overflow = full_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= uvc_pkg::ST_CLEAR;
            clr_reg   <= '0;
            total_reg <= '0;
            full_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            total_reg <= total_next;
            full_reg  <= full_next;
        end
        value_reg <= value_next;
        last_reg  <= last_next;
        pos_reg   <= pos_next;
        tries_reg <= tries_next;
    end

endmodule

FILE: rtl/unique_value_counter_core.sv
`timescale 1ns / 1ps

// Counts the values that occur exactly once in a set streamed in one 32-bit
// value per transfer, the set's final value marked by s_tlast. Values go into
// an open-addressed table of TABLE_DEPTH slots (home slot = value mod depth,
// linear probing with wrap), each slot holding the key and a saturating count
// of 0, 1 or 2-and-more. After the marked value is entered, one result
// transfer carries the number of single-occurrence values (saturating at 2047)
// and an overflow flag, set if some new value found the table full and was
// dropped; no result follows unmarked values. A value gets its home slot
// from the shared remainder unit (4 bits per cycle for a non-power-of-two
// depth) and then probes slots in turn until one resolves it or all are tried.
// Each probe is a read then a check/update on the single-port slot RAM, which
// sets the probe cost. After the marked value the block hands over the result
// (waiting while an earlier result still sits in the output register) and
// then sweeps all TABLE_DEPTH slots clear; the same sweep runs after reset.
// s_tready is low throughout. The result sits in an output register, so the
// sweep and the next set can proceed while the previous result waits for
// m_tready.
module unique_value_counter_core #(
    parameter int TABLE_DEPTH = 1024
) (
    input  logic        aclk,
    input  logic        aresetn,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] value
    input  logic        s_tlast,   // last value of the set
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // [10:0] singles, [11] overflow, [15:12] zero
);

    localparam int AW = $clog2(TABLE_DEPTH);

    logic                 mod_start;
    logic                 mod_done;
    logic [AW-1:0]        mod_rem;

    uvc_pkg::ram_cmd_t    ram_cmd;
    logic [AW-1:0]        ram_addr;
    uvc_pkg::slot_t       ram_wdata;
    uvc_pkg::slot_t       ram_rdata;

    logic                 out_free;
    logic                 res_valid;
    uvc_pkg::result_t     res_data;

    // output register
    logic                 m_valid_reg, m_valid_next;
    uvc_pkg::result_t     m_data_reg, m_data_next;

    // shared remainder unit: value -> home slot
    uvc_mod_unit #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_mod (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (mod_start),
        .value_in (s_tdata),
        .done     (mod_done),
        .rem      (mod_rem)
    );

    // key + count store
    uvc_slot_ram #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_ram (
        .aclk  (aclk),
        .cmd   (ram_cmd),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    // probe sequencer
    uvc_probe_ctrl #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_value  (s_tdata),
        .in_last   (s_tlast),
        .in_ready  (s_tready),
        .mod_start (mod_start),
        .mod_done  (mod_done),
        .mod_rem   (mod_rem),
        .ram_cmd   (ram_cmd),
        .ram_addr  (ram_addr),
        .ram_wdata (ram_wdata),
        .ram_rdata (ram_rdata),
        .out_free  (out_free),
        .res_valid (res_valid),
        .res_data  (res_data)
    );

    // Output slot is free when empty or being drained this cycle
    assign out_free = !m_valid_reg || m_tready;

    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (res_valid) begin
            m_valid_next = 1'b1;
            m_data_next  = res_data;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
        m_data_reg <= m_data_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {4'b0000, m_data_reg.overflow, m_data_reg.singles};

    // A result is only loaded when the output slot can take it
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid |-> (!m_valid_reg || m_tready))
        else $error("result loaded over an undelivered one");

    // Loaded result is presented on the next cycle
    a_result_shown: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid |=> m_tvalid)
        else $error("loaded result not presented");

    // Remainder unit only finishes while a value is in progress
    a_mod_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        mod_done |-> !s_tready)
        else $error("remainder finished while idle");

    // Slot RAM is single-port
    a_ram_port: assert property (@(posedge aclk) disable iff (!aresetn)
        !(ram_cmd.rd_en && ram_cmd.wr_en))
        else $error("slot RAM read and write in one cycle");

    // No new value is taken while a result is being handed over
    a_ready_report: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid |-> !s_tready)
        else $error("input ready during result hand-over");

endmodule
